[rtl/sal_pkg.sv]
// Shared types, constants and the mnemonic table of the stack assembler front end.
package sal_pkg;

  localparam logic [1:0] KIND_INSTR = 2'd0;
  localparam logic [1:0] KIND_ERR   = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [2:0] ERR_UNKNOWN_WORD = 3'd1;
  localparam logic [2:0] ERR_BAD_CHAR     = 3'd2;
  localparam logic [2:0] ERR_NO_OPERAND   = 3'd3;
  localparam logic [2:0] ERR_STRAY_NUMBER = 3'd4;
  localparam logic [2:0] ERR_WORD_LONG    = 3'd5;
  localparam logic [2:0] ERR_NUMBER_LARGE = 3'd6;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int NUM_MNEM = 21;

  // first letter in the highest used byte, unused upper bytes zero
  localparam logic [39:0] MNEM_TEXT [NUM_MNEM] = '{
    40'("push"), 40'("pop"), 40'("add"), 40'("sub"), 40'("mul"), 40'("div"), 40'("mod"),
    40'("cmpe"), 40'("cmpne"), 40'("cmpl"), 40'("cmple"), 40'("cmpg"), 40'("cmpge"),
    40'("jmp"), 40'("jmpz"), 40'("jmpnz"), 40'("dup"), 40'("dupi"), 40'("swp"),
    40'("swpi"), 40'("hlt")
  };

  localparam logic [2:0] MNEM_LEN [NUM_MNEM] = '{
    3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5,
    3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3
  };

  // push, jmp, jmpz, jmpnz, dupi, swpi
  localparam logic [NUM_MNEM-1:0] TAKES_OPERAND = 21'b0_1010_1110_0000_0000_0001;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  opcode;
    logic [30:0] operand;
    logic [2:0]  error_code;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        end_of_source;
  } res_t;

  // results written to the queue together in the same cycle
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] op;
  } look_t;

  function automatic look_t mnem_lookup(logic [39:0] word, logic [4:0] len);
    look_t lk;
    lk = '0;
    for (int i = 0; i < NUM_MNEM; i++) begin
      if (!lk.hit && len == {2'b00, MNEM_LEN[i]} && word == MNEM_TEXT[i]) begin
        lk.hit = 1'b1;
        lk.op  = 5'(i);
      end
    end
    return lk;
  endfunction

  function automatic res_t mk_err(logic [2:0] code, logic [15:0] line, logic [15:0] col);
    res_t r;
    r = '0;
    r.kind          = KIND_ERR;
    r.error_code    = code;
    r.line_number   = line;
    r.column_number = col;
    return r;
  endfunction

  function automatic res_t mk_instr(logic [4:0] op, logic [30:0] val,
                                    logic [15:0] line, logic [15:0] col);
    res_t r;
    r = '0;
    r.kind          = KIND_INSTR;
    r.opcode        = op;
    r.operand       = val;
    r.line_number   = line;
    r.column_number = col;
    return r;
  endfunction

  // append a result; a third one in the same item is dropped
  function automatic push_t push_res(push_t p, res_t r);
    push_t q;
    q = p;
    if (p.n == 2'd0) begin
      q.r0 = r;
      q.n  = 2'd1;
    end else if (p.n == 2'd1) begin
      q.r1 = r;
      q.n  = 2'd2;
    end
    return q;
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

[rtl/sal_res_fifo.sv]
// Four-entry result queue taking up to two results per cycle and giving one when out_ready is high.
module sal_res_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  sal_pkg::push_t  push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output sal_pkg::res_t   out_res
);

  sal_pkg::res_t mem [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = mem[rp_r];
  assign pop       = out_valid && out_ready;

  assign wp_nxt  = wp_r + push.n;
  assign rp_nxt  = rp_r + {1'b0, pop};
  assign cnt_nxt = cnt_r + {1'b0, push.n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wp_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wp_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/stack_asm_lexer_assembler_core.sv]
// Stack-machine assembler front end: takes source text one byte per item and gives
// instructions, errors and end markers. An accepted byte sits in an input register and
// is lexed, once the result queue has room, by one pass of logic (parallel mnemonic
// compare, times-ten accumulate); its results are written into a four-entry result
// queue. A byte is taken every cycle while the queue keeps room for two results, so
// the rate is one byte per cycle as long as results drain at least as fast as they
// are made; a byte that yields two results (a token closed together with an error,
// or two tokens closed by the last byte) puts both into the queue at once. After an
// error, bytes up to the last byte are taken and dropped.
module stack_asm_lexer_assembler_core #(
  parameter int MAX_WORD_LEN = 9,
  parameter int MAX_DIGITS   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [4:0]  out_opcode,
  output logic [30:0] out_operand,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_line_number,
  output logic [15:0] out_column_number,
  output logic        out_end_of_source
);

  localparam int CNT_MAX = (MAX_WORD_LEN > MAX_DIGITS) ? MAX_WORD_LEN : MAX_DIGITS;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam logic [CNT_W-1:0] WORD_LIM = CNT_W'(MAX_WORD_LEN);
  localparam logic [CNT_W-1:0] DIG_LIM  = CNT_W'(MAX_DIGITS);

  localparam logic [1:0] TOK_NONE = 2'd0;
  localparam logic [1:0] TOK_WORD = 2'd1;
  localparam logic [1:0] TOK_NUM  = 2'd2;

  typedef struct packed {
    logic [1:0]       tok;
    logic [CNT_W-1:0] cnt;
    logic [30:0]      num;
    logic [4:0]       wop;
    logic             waiting;
    logic [15:0]      line;
    logic [15:0]      col;
    logic [15:0]      tcol;
    logic             drop;
    logic [15:0]      wline;
    logic [15:0]      wcol;
  } st_t;

  typedef struct packed {
    st_t           st;
    logic          hit;
    sal_pkg::res_t res;
  } fin_t;

  // close the open token, if any
  function automatic fin_t finish_tok(st_t s, logic [39:0] word);
    fin_t           f;
    sal_pkg::look_t lk;
    f     = '0;
    f.st  = s;
    lk    = sal_pkg::mnem_lookup(word, 5'(s.cnt));
    if (s.tok == TOK_WORD) begin
      f.st.tok = TOK_NONE;
      if (!lk.hit) begin
        f.hit     = 1'b1;
        f.res     = sal_pkg::mk_err(sal_pkg::ERR_UNKNOWN_WORD, s.line, s.tcol);
        f.st.drop = 1'b1;
      end else if (s.waiting) begin
        f.hit     = 1'b1;
        f.res     = sal_pkg::mk_err(sal_pkg::ERR_NO_OPERAND, s.wline, s.wcol);
        f.st.drop = 1'b1;
      end else if (sal_pkg::TAKES_OPERAND[lk.op]) begin
        f.st.waiting = 1'b1;
        f.st.wop     = lk.op;
        f.st.wline   = s.line;
        f.st.wcol    = s.tcol;
      end else begin
        f.hit = 1'b1;
        f.res = sal_pkg::mk_instr(lk.op, 31'd0, s.line, s.tcol);
      end
    end else if (s.tok == TOK_NUM) begin
      f.st.tok = TOK_NONE;
      if (s.waiting) begin
        f.hit        = 1'b1;
        f.res        = sal_pkg::mk_instr(s.wop, s.num, s.wline, s.wcol);
        f.st.waiting = 1'b0;
      end else begin
        f.hit     = 1'b1;
        f.res     = sal_pkg::mk_err(sal_pkg::ERR_STRAY_NUMBER, s.line, s.tcol);
        f.st.drop = 1'b1;
      end
    end
    return f;
  endfunction

  logic            v_r;
  logic [7:0]      c_r;
  logic            last_r;
  st_t             st_r, st_nxt;
  logic [39:0]     word_r, word_nxt;
  fin_t            fin_a, fin_b;
  sal_pkg::push_t  push;
  sal_pkg::res_t   end_res;
  sal_pkg::res_t   out_res;
  logic            room;
  logic            go;
  logic            in_acc;
  logic            is_let;
  logic            is_dig;
  logic [34:0]     prod;

  assign go       = v_r && room;
  assign in_ready = !v_r || room;
  assign in_acc   = in_valid && in_ready;

  assign is_let = (c_r >= "a" && c_r <= "z") || (c_r >= "A" && c_r <= "Z");
  assign is_dig = (c_r >= "0" && c_r <= "9");
  assign prod   = ({4'd0, st_r.num} << 3) + ({4'd0, st_r.num} << 1)
                + {31'd0, c_r[3:0]};

  always_comb begin
    end_res      = '0;
    end_res.kind = sal_pkg::KIND_END;
  end

  always_comb begin
    st_nxt   = st_r;
    word_nxt = word_r;
    push     = '0;
    fin_a    = '0;
    fin_b    = '0;
    if (go) begin
      if (!st_nxt.drop) begin
        if (st_nxt.tok == TOK_WORD && is_let) begin
          if (st_nxt.cnt >= WORD_LIM) begin
            push = sal_pkg::push_res(push,
                     sal_pkg::mk_err(sal_pkg::ERR_WORD_LONG, st_nxt.line, st_nxt.tcol));
            st_nxt.drop = 1'b1;
          end else begin
            word_nxt   = {word_nxt[31:0], c_r};
            st_nxt.cnt = st_nxt.cnt + CNT_W'(1);
            st_nxt.col = sal_pkg::sat_inc(st_nxt.col);
          end
        end else if (st_nxt.tok == TOK_NUM && is_dig) begin
          if (st_nxt.cnt >= DIG_LIM || prod[34:31] != 4'd0) begin
            push = sal_pkg::push_res(push,
                     sal_pkg::mk_err(sal_pkg::ERR_NUMBER_LARGE, st_nxt.line, st_nxt.tcol));
            st_nxt.drop = 1'b1;
          end else begin
            st_nxt.num = prod[30:0];
            st_nxt.cnt = st_nxt.cnt + CNT_W'(1);
            st_nxt.col = sal_pkg::sat_inc(st_nxt.col);
          end
        end else begin
          fin_a  = finish_tok(st_nxt, word_nxt);
          st_nxt = fin_a.st;
          if (fin_a.hit) begin
            push = sal_pkg::push_res(push, fin_a.res);
          end
          if (!st_nxt.drop) begin
            priority if (is_let) begin
              st_nxt.tok  = TOK_WORD;
              word_nxt    = {32'd0, c_r};
              st_nxt.cnt  = CNT_W'(1);
              st_nxt.tcol = st_nxt.col;
              st_nxt.col  = sal_pkg::sat_inc(st_nxt.col);
            end else if (is_dig) begin
              st_nxt.tok  = TOK_NUM;
              st_nxt.num  = {27'd0, c_r[3:0]};
              st_nxt.cnt  = CNT_W'(1);
              st_nxt.tcol = st_nxt.col;
              st_nxt.col  = sal_pkg::sat_inc(st_nxt.col);
            end else if (c_r == sal_pkg::CH_SPACE) begin
              st_nxt.col = sal_pkg::sat_inc(st_nxt.col);
            end else if (c_r == sal_pkg::CH_NL) begin
              st_nxt.line = sal_pkg::sat_inc(st_nxt.line);
              st_nxt.col  = 16'd0;
            end else begin
              push = sal_pkg::push_res(push,
                       sal_pkg::mk_err(sal_pkg::ERR_BAD_CHAR, st_nxt.line, st_nxt.col));
              st_nxt.drop = 1'b1;
            end
          end
        end
        // last byte: close the open token and check for a dangling operand
        if (last_r && !st_nxt.drop) begin
          fin_b  = finish_tok(st_nxt, word_nxt);
          st_nxt = fin_b.st;
          if (fin_b.hit) begin
            push = sal_pkg::push_res(push, fin_b.res);
          end
          if (!st_nxt.drop && st_nxt.waiting) begin
            push = sal_pkg::push_res(push,
                     sal_pkg::mk_err(sal_pkg::ERR_NO_OPERAND, st_nxt.wline, st_nxt.wcol));
            st_nxt.drop = 1'b1;
          end
        end
      end
      if (last_r) begin
        if (push.n == 2'd0) begin
          push = sal_pkg::push_res(push, end_res);
        end
        if (push.n == 2'd1) begin
          push.r0.end_of_source = 1'b1;
        end else begin
          push.r1.end_of_source = 1'b1;
        end
        st_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      c_r    <= in_char_byte;
      last_r <= in_last_byte;
    end
    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      st_r <= '0;
    end else begin
      v_r  <= in_acc ? 1'b1 : (go ? 1'b0 : v_r);
      st_r <= st_nxt;
    end
  end

  sal_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_opcode        = out_res.opcode;
  assign out_operand       = out_res.operand;
  assign out_error_code    = out_res.error_code;
  assign out_line_number   = out_res.line_number;
  assign out_column_number = out_res.column_number;
  assign out_end_of_source = out_res.end_of_source;

endmodule

[dv/stack_asm_lexer_assembler_core_tb.sv]
// Self-checking testbench for the stack assembler front end: byte streams in, instructions out.
`timescale 1ns / 100ps

module stack_asm_lexer_assembler_core_tb;

  localparam int MAX_WORD_LEN = 9;
  localparam int MAX_DIGITS   = 10;
  localparam logic [31:0] OPERAND_MAX = 32'h7FFF_FFFF;
  localparam logic [2:0]  ERR_NONE    = 3'd0;
  localparam logic [7:0]  CH_TAB      = 8'h09;
  localparam int STALL_LIMIT  = 1000;
  localparam int PRINT_LIMIT  = 50;

  typedef enum logic [4:0] {
    OP_PUSH, OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
    OP_CMPE, OP_CMPNE, OP_CMPL, OP_CMPLE, OP_CMPG, OP_CMPGE,
    OP_JMP, OP_JMPZ, OP_JMPNZ, OP_DUP, OP_DUPI, OP_SWP, OP_SWPI, OP_HLT
  } opcode_t;

  typedef enum logic [1:0] {TOK_NONE, TOK_WORD, TOK_NUM} tok_kind_t;

  string mnemonic_text [sal_pkg::NUM_MNEM] = '{
    "push", "pop", "add", "sub", "mul", "div", "mod",
    "cmpe", "cmpne", "cmpl", "cmple", "cmpg", "cmpge",
    "jmp", "jmpz", "jmpnz", "dup", "dupi", "swp", "swpi", "hlt"
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [4:0]  out_opcode;
  logic [30:0] out_operand;
  logic [2:0]  out_error_code;
  logic [15:0] out_line_number;
  logic [15:0] out_column_number;
  logic        out_end_of_source;

  stack_asm_lexer_assembler_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_byte      (in_char_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_opcode        (out_opcode),
    .out_operand       (out_operand),
    .out_error_code    (out_error_code),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_end_of_source (out_end_of_source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- lexer predictor
  byte unsigned  word_buf [MAX_WORD_LEN];
  int            tok_len;
  logic [31:0]   num_val;
  tok_kind_t     tok_kind;
  opcode_t       pend_op;
  bit            pend_valid;
  logic [15:0]   pend_line, pend_col;
  logic [15:0]   line_cnt, col_cnt, tok_col;
  bit            skipping;
  sal_pkg::res_t step_res [2];
  int            step_cnt;
  sal_pkg::res_t expected_results [$];

  function automatic void clear_lexer();
    foreach (word_buf[i]) word_buf[i] = 8'd0;
    tok_len    = 0;
    num_val    = '0;
    tok_kind   = TOK_NONE;
    pend_op    = OP_PUSH;
    pend_valid = 1'b0;
    pend_line  = '0;
    pend_col   = '0;
    line_cnt   = '0;
    col_cnt    = '0;
    tok_col    = '0;
    skipping   = 1'b0;
  endfunction

  function automatic bit needs_operand(opcode_t op);
    case (op)
      OP_PUSH, OP_JMP, OP_JMPZ, OP_JMPNZ, OP_DUPI, OP_SWPI: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // at most two results per byte; anything beyond is lost
  function automatic void add_result(logic [1:0] kind, logic [4:0] op, logic [30:0] val,
                                     logic [2:0] code, logic [15:0] line, logic [15:0] col);
    sal_pkg::res_t r;
    r = '0;
    r.kind          = kind;
    r.opcode        = op;
    r.operand       = val;
    r.error_code    = code;
    r.line_number   = line;
    r.column_number = col;
    if (step_cnt < 2) begin
      step_res[step_cnt] = r;
      step_cnt++;
    end
  endfunction

  function automatic void flag_error(logic [2:0] code, logic [15:0] line, logic [15:0] col);
    add_result(sal_pkg::KIND_ERR, '0, '0, code, line, col);
    skipping = 1'b1;
  endfunction

  function automatic void advance_col();
    if (col_cnt != 16'hFFFF) col_cnt = col_cnt + 16'd1;
  endfunction

  function automatic int find_mnemonic();
    int  hit;
    bit  same;
    hit = -1;
    for (int i = 0; i < sal_pkg::NUM_MNEM; i++) begin
      if (hit < 0 && mnemonic_text[i].len() == tok_len) begin
        same = 1'b1;
        for (int j = 0; j < tok_len; j++)
          if (mnemonic_text[i][j] != word_buf[j]) same = 1'b0;
        if (same) hit = i;
      end
    end
    return hit;
  endfunction

  function automatic void close_token();
    int idx;
    if (tok_kind == TOK_WORD) begin
      idx = find_mnemonic();
      tok_kind = TOK_NONE;
      if (idx < 0) begin
        flag_error(sal_pkg::ERR_UNKNOWN_WORD, line_cnt, tok_col);
      end else if (pend_valid) begin
        flag_error(sal_pkg::ERR_NO_OPERAND, pend_line, pend_col);
      end else if (needs_operand(opcode_t'(idx))) begin
        pend_valid = 1'b1;
        pend_op    = opcode_t'(idx);
        pend_line  = line_cnt;
        pend_col   = tok_col;
      end else begin
        add_result(sal_pkg::KIND_INSTR, 5'(idx), '0, ERR_NONE, line_cnt, tok_col);
      end
    end else if (tok_kind == TOK_NUM) begin
      tok_kind = TOK_NONE;
      if (pend_valid) begin
        add_result(sal_pkg::KIND_INSTR, pend_op, num_val[30:0], ERR_NONE,
                   pend_line, pend_col);
        pend_valid = 1'b0;
      end else begin
        flag_error(sal_pkg::ERR_STRAY_NUMBER, line_cnt, tok_col);
      end
    end
  endfunction

  function automatic void lex_char(byte unsigned c);
    bit          is_alpha;
    bit          is_num;
    logic [31:0] dig;
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    is_num   = (c >= "0" && c <= "9");
    dig      = is_num ? 32'(c - 8'h30) : 32'd0;
    if (tok_kind == TOK_WORD && is_alpha) begin
      if (tok_len >= MAX_WORD_LEN) begin
        flag_error(sal_pkg::ERR_WORD_LONG, line_cnt, tok_col);
        return;
      end
      word_buf[tok_len] = c;
      tok_len++;
      advance_col();
      return;
    end
    if (tok_kind == TOK_NUM && is_num) begin
      if (tok_len >= MAX_DIGITS || num_val > (OPERAND_MAX - dig) / 32'd10) begin
        flag_error(sal_pkg::ERR_NUMBER_LARGE, line_cnt, tok_col);
        return;
      end
      num_val = num_val * 32'd10 + dig;
      tok_len++;
      advance_col();
      return;
    end
    close_token();
    if (skipping) return;
    if (is_alpha) begin
      tok_kind    = TOK_WORD;
      word_buf[0] = c;
      tok_len     = 1;
      tok_col     = col_cnt;
      advance_col();
    end else if (is_num) begin
      tok_kind = TOK_NUM;
      num_val  = dig;
      tok_len  = 1;
      tok_col  = col_cnt;
      advance_col();
    end else if (c == sal_pkg::CH_SPACE) begin
      advance_col();
    end else if (c == sal_pkg::CH_NL) begin
      if (line_cnt != 16'hFFFF) line_cnt = line_cnt + 16'd1;
      col_cnt = '0;
    end else begin
      flag_error(sal_pkg::ERR_BAD_CHAR, line_cnt, col_cnt);
    end
  endfunction

  function automatic void predict_byte(byte unsigned c, bit last);
    step_cnt = 0;
    if (!skipping) begin
      lex_char(c);
      if (last && !skipping) begin
        close_token();
        if (!skipping && pend_valid) flag_error(sal_pkg::ERR_NO_OPERAND, pend_line, pend_col);
      end
    end
    if (last) begin
      if (step_cnt == 0) add_result(sal_pkg::KIND_END, '0, '0, ERR_NONE, '0, '0);
      step_res[step_cnt-1].end_of_source = 1'b1;
      clear_lexer();
    end
    for (int i = 0; i < step_cnt; i++) expected_results.push_back(step_res[i]);
  endfunction

  // ---------------------------------------------------------------- checking
  int                           mismatch_count = 0;
  int                           instr_count = 0;
  int                           error_count = 0;
  int                           end_count = 0;
  logic [sal_pkg::NUM_MNEM-1:0] ops_seen = '0;
  logic [7:0]                   errs_seen = '0;

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    sal_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with nothing expected", 32'(out_kind), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind)
          note_mismatch("kind", 32'(out_kind), 32'(want.kind));
        if (out_opcode !== want.opcode)
          note_mismatch("opcode", 32'(out_opcode), 32'(want.opcode));
        if (out_operand !== want.operand)
          note_mismatch("operand", 32'(out_operand), 32'(want.operand));
        if (out_error_code !== want.error_code)
          note_mismatch("error_code", 32'(out_error_code), 32'(want.error_code));
        if (out_line_number !== want.line_number)
          note_mismatch("line_number", 32'(out_line_number), 32'(want.line_number));
        if (out_column_number !== want.column_number)
          note_mismatch("column_number", 32'(out_column_number), 32'(want.column_number));
        if (out_end_of_source !== want.end_of_source)
          note_mismatch("end_of_source", 32'(out_end_of_source), 32'(want.end_of_source));
        case (want.kind)
          sal_pkg::KIND_INSTR: begin
            instr_count++;
            ops_seen[want.opcode] = 1'b1;
          end
          sal_pkg::KIND_ERR: begin
            error_count++;
            errs_seen[want.error_code] = 1'b1;
          end
          default: end_count++;
        endcase
      end
    end
    if (rst_n && in_valid && in_ready) predict_byte(in_char_byte, in_last_byte);
  end

  // watchdog: any handshake restarts the count
  int idle_run = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- result receiver
  int src_idle_pct = 35;
  int sink_idle_pct = 53;
  int hold_off_cycles = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------- byte sender
  byte unsigned src_text [$];
  int           bytes_sent = 0;
  int           sources_sent = 0;

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_byte(byte unsigned c, bit last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= c;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_source();
    for (int i = 0; i < src_text.size(); i++) send_byte(src_text[i], i == src_text.size() - 1);
    src_text.delete();
    sources_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic append_text(string s);
    for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
  endtask

  task automatic append_sep(bit allow_empty);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0 && allow_empty) return;   // glued tokens
    if (pick < 14) src_text.push_back(sal_pkg::CH_SPACE);
    else if (pick < 18) src_text.push_back(sal_pkg::CH_NL);
    else repeat ($urandom_range(2, 5))
      src_text.push_back($urandom_range(0, 1) ? sal_pkg::CH_NL : sal_pkg::CH_SPACE);
  endtask

  task automatic append_number();
    int unsigned v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 9);
      1: v = $urandom_range(0, 999);
      2: v = $urandom_range(0, OPERAND_MAX);
      3: v = OPERAND_MAX - $urandom_range(0, 3);
      4: begin
        append_text("00");
        v = $urandom_range(0, 99);
      end
      default: v = $urandom_range(0, 65535);
    endcase
    append_text($sformatf("%0d", v));
  endtask

  task automatic append_fault();
    case ($urandom_range(0, 6))
      0: src_text.push_back(8'($urandom_range(0, 255)));
      1: repeat ($urandom_range(1, 4)) src_text.push_back(8'($urandom_range(8'h41, 8'h5A)));
      2: append_number();
      3: repeat ($urandom_range(MAX_WORD_LEN + 1, MAX_WORD_LEN + 3))
           src_text.push_back(8'($urandom_range(8'h61, 8'h7A)));
      4: append_text($sformatf("%0d", 64'h8000_0000 + 64'($urandom_range(0, OPERAND_MAX))));
      5: append_text("000000000000");
      default: repeat ($urandom_range(2, MAX_WORD_LEN))
                 src_text.push_back(8'($urandom_range(8'h61, 8'h7A)));
    endcase
    append_sep(1'b0);
  endtask

  task automatic build_program(int n_instr, bit with_faults);
    opcode_t op;
    for (int k = 0; k < n_instr; k++) begin
      if (k > 0 || $urandom_range(0, 3) == 0) append_sep(with_faults);
      if (with_faults && $urandom_range(0, 9) == 0) append_fault();
      op = opcode_t'($urandom_range(0, sal_pkg::NUM_MNEM - 1));
      append_text(mnemonic_text[op]);
      // an operand may be glued to its mnemonic, or left out on purpose
      if (needs_operand(op) && !(with_faults && $urandom_range(0, 9) == 0)) begin
        append_sep(1'b1);
        append_number();
      end
    end
    if ($urandom_range(0, 1)) src_text.push_back(sal_pkg::CH_NL);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic send_text(string s);
    append_text(s);
    send_source();
  endtask

  task automatic test_special_cases();
    send_text("push 2147483647");   // largest operand, token closed by the last byte
    send_text("jmp 2147483648");    // value overflow
    send_text("dupi 00000000000");  // too many digits
    send_text("hlt\nabcdefghij");   // word too long on second line
    send_text("Pop");               // upper case never matches
    send_text("swp 7");             // number with no mnemonic waiting
    send_text("jmpz add");          // mnemonic lacks its operand
    send_text("swpi zz");           // unknown word wins over missing operand
    send_text("jmpnz");             // operand still missing at the end
    append_text("mod");             // two results on the last byte
    src_text.push_back(CH_TAB);
    send_source();
    send_text(" ");                 // end marker only
    src_text.push_back(8'hFF);
    send_source();
    src_text.push_back(8'h00);      // error then dropped up to the last byte
    src_text.push_back(8'h80);
    append_text("a");
    send_source();
    wait_drained();
  endtask

  task automatic test_random_sources(int src_pct, int sink_pct, int n_bytes);
    int base;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    base = bytes_sent;
    while (bytes_sent - base < n_bytes) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 12)) src_text.push_back(8'($urandom_range(0, 255)));
      else
        build_program($urandom_range(1, 6), $urandom_range(0, 9) < 7);
      send_source();
    end
    wait_drained();
  endtask

  // receiver holds off long enough for the result queue to fill and block input
  task automatic test_output_stall();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    @(posedge clk);
    hold_off_cycles = 80;
    @(negedge clk);
    build_program(16, 1'b0);
    send_source();
    wait_drained();
  endtask

  initial begin
    clear_lexer();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_random_sources(35, 53, 100);
    test_random_sources(53, 35, 100);
    test_random_sources(0, 0, 100);
    test_output_stall();
    repeat (8) @(negedge clk);
    $display("ran %0d bytes in %0d sources; checked %0d instructions, %0d errors, %0d end markers",
             bytes_sent, sources_sent, instr_count, error_count, end_count);
    $display("mnemonics seen: %0d of %0d, error codes seen: %b",
             $countones(ops_seen), sal_pkg::NUM_MNEM, errs_seen);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
